// ===== design/pos_pkg.sv =====
// Shared types and constants for the point-on-surface test.
package pos_pkg;

  typedef enum logic [1:0] {
    OP_PLANE    = 2'd0,
    OP_CYLINDER = 2'd1,
    OP_SPHERE   = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned BACK_STAGES = 6;
  localparam logic [15:0] TOL_RESET   = 16'd1;

  typedef struct packed {
    op_e                op;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic        [30:0] dia;
    logic        [30:0] hgt;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
  } queue_ctl_t;

endpackage

// ===== design/pos_front.sv =====
// Front part: takes a request and forms the point offsets for the queue.
module pos_front (
  input  logic                  in_valid_i,
  input  logic                  queue_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  input  logic [1:0]            operation_i,
  input  logic signed [31:0]    ref_x_i,
  input  logic signed [31:0]    ref_y_i,
  input  logic signed [31:0]    ref_z_i,
  input  logic signed [17:0]    axis_x_i,
  input  logic signed [17:0]    axis_y_i,
  input  logic signed [17:0]    axis_z_i,
  input  logic [30:0]           diameter_i,
  input  logic [30:0]           height_i,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  input  logic signed [31:0]    point_z_i,
  output pos_pkg::entry_t       entry_o
);
  import pos_pkg::*;

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    entry_o.op  = op_e'(operation_i);
    entry_o.dx  = 33'(point_x_i) - 33'(ref_x_i);
    entry_o.dy  = 33'(point_y_i) - 33'(ref_y_i);
    entry_o.dz  = 33'(point_z_i) - 33'(ref_z_i);
    entry_o.ax  = axis_x_i;
    entry_o.ay  = axis_y_i;
    entry_o.az  = axis_z_i;
    entry_o.dia = diameter_i;
    entry_o.hgt = height_i;
  end

endmodule

// ===== design/pos_queue.sv =====
// Short request queue between the front and back parts.
module pos_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pos_pkg::queue_ctl_t ctl_i,
  input  pos_pkg::entry_t     entry_i,
  output pos_pkg::entry_t     entry_o,
  output logic                full_o,
  output logic                empty_o
);
  import pos_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (ctl_i.push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (ctl_i.pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (ctl_i.push && !ctl_i.pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!ctl_i.push && ctl_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== design/pos_back.sv =====
// Back part: six-stage arithmetic pipeline that evaluates one surface test.
module pos_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     tol_i,
  input  logic            avail_i,
  input  pos_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            on_surface_o
);
  import pos_pkg::*;

  localparam logic [63:0] SqCap = 64'd1 << 61;

  logic               en;
  logic [BACK_STAGES-1:0] vld_q;

  logic signed [32:0] d1_q [3];
  logic signed [17:0] a1_q [3];
  logic signed [50:0] p1_q [3];
  logic        [61:0] sq1_q [3];
  logic               ov1_q;
  logic        [61:0] d2_1_q;
  logic        [30:0] h1_q;
  op_e                op1_q;

  logic signed [32:0] d2_q [3];
  logic signed [17:0] a2_q [3];
  logic signed [37:0] hq2_q;
  logic        [61:0] dd2_q;
  op_e                op2_q;
  logic               pl2_q, sp2_q, nr2_q, in2_q, st2_q;

  logic signed [32:0] d3_q [3];
  logic signed [55:0] p3_q [3];
  logic        [61:0] dd3_q;
  op_e                op3_q;
  logic               pl3_q, sp3_q, nr3_q, in3_q, st3_q;

  logic        [30:0] rm4_q [3];
  logic               ov4_q;
  logic        [61:0] dd4_q;
  op_e                op4_q;
  logic               pl4_q, sp4_q, nr4_q, in4_q, st4_q;

  logic        [61:0] sq5_q [3];
  logic               ov5_q;
  logic        [61:0] dd5_q;
  op_e                op5_q;
  logic               pl5_q, sp5_q, nr5_q, in5_q, st5_q;

  logic               res_q;

  logic        [32:0] dm [3];
  logic signed [52:0] dot;
  logic signed [53:0] dot_r;
  logic signed [53:0] dot_h;
  logic        [52:0] dot_m;
  logic        [53:0] dot_hm;
  logic        [46:0] hq32;
  logic        [31:0] tq;
  logic        [33:0] tr;
  logic        [63:0] n_s2, n4_s2;
  logic        [63:0] n_s6, n4_s6;
  logic signed [56:0] pr [3];
  logic signed [41:0] rr [3];
  logic        [41:0] rm [3];
  logic               ov_r;
  logic               nr_ok, rd_ok, cyl;

  assign en          = ~(vld_q[BACK_STAGES-1] & out_stall_i);
  assign pop_o       = en & avail_i;
  assign out_valid_o = vld_q[BACK_STAGES-1];
  assign on_surface_o = res_q;
  assign tq          = {tol_i, 16'b0};
  assign tr          = {tol_i, 18'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_STAGES-2:0], avail_i};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm[i] = 33'(0);
    end
    dm[0] = entry_i.dx[32] ? 33'(-entry_i.dx) : 33'(entry_i.dx);
    dm[1] = entry_i.dy[32] ? 33'(-entry_i.dy) : 33'(entry_i.dy);
    dm[2] = entry_i.dz[32] ? 33'(-entry_i.dz) : 33'(entry_i.dz);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= entry_i.dx;
      d1_q[1] <= entry_i.dy;
      d1_q[2] <= entry_i.dz;
      a1_q[0] <= entry_i.ax;
      a1_q[1] <= entry_i.ay;
      a1_q[2] <= entry_i.az;
      p1_q[0] <= 51'(entry_i.dx) * 51'(entry_i.ax);
      p1_q[1] <= 51'(entry_i.dy) * 51'(entry_i.ay);
      p1_q[2] <= 51'(entry_i.dz) * 51'(entry_i.az);
      for (int i = 0; i < 3; i++) begin
        sq1_q[i] <= 62'(dm[i][30:0]) * 62'(dm[i][30:0]);
      end
      ov1_q  <= (dm[0][32:31] != 2'b0) | (dm[1][32:31] != 2'b0) | (dm[2][32:31] != 2'b0);
      d2_1_q <= 62'(entry_i.dia) * 62'(entry_i.dia);
      h1_q   <= entry_i.hgt;
      op1_q  <= entry_i.op;
    end
  end

  always_comb begin
    dot    = 53'(p1_q[0]) + 53'(p1_q[1]) + 53'(p1_q[2]);
    dot_r  = 54'(dot) + 54'sd32768;
    hq32   = {h1_q, 16'b0};
    dot_h  = 54'(dot) - $signed({7'b0, hq32});
    dot_m  = dot[52] ? 53'(-dot) : 53'(dot);
    dot_hm = dot_h[53] ? 54'(-dot_h) : 54'(dot_h);
    n_s2   = 64'(sq1_q[0]) + 64'(sq1_q[1]) + 64'(sq1_q[2]);
    if (ov1_q || n_s2 > SqCap) begin
      n_s2 = SqCap;
    end
    n4_s2 = n_s2 << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q  <= d1_q;
      a2_q  <= a1_q;
      hq2_q <= dot_r[53:16];
      dd2_q <= d2_1_q;
      op2_q <= op1_q;
      pl2_q <= (dot_m <= 53'(tq));
      sp2_q <= ((n4_s2 > 64'(d2_1_q)) ? (n4_s2 - 64'(d2_1_q)) : (64'(d2_1_q) - n4_s2))
               <= 64'(tr);
      nr2_q <= (dot_m <= 53'(tq)) | (dot_hm <= 54'(tq));
      in2_q <= ~dot[52] & (dot <= $signed({6'b0, hq32}));
      st2_q <= ~dot[52] & (dot != '0) & (dot < $signed({6'b0, hq32}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q  <= d2_q;
      for (int i = 0; i < 3; i++) begin
        p3_q[i] <= 56'(hq2_q) * 56'(a2_q[i]);
      end
      dd3_q <= dd2_q;
      op3_q <= op2_q;
      pl3_q <= pl2_q;
      sp3_q <= sp2_q;
      nr3_q <= nr2_q;
      in3_q <= in2_q;
      st3_q <= st2_q;
    end
  end

  always_comb begin
    ov_r = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pr[i] = 57'(p3_q[i]) + 57'sd32768;
      rr[i] = 42'(d3_q[i]) - 42'($signed(pr[i][56:16]));
      rm[i] = rr[i][41] ? 42'(-rr[i]) : 42'(rr[i]);
      ov_r  = ov_r | (rm[i][41:31] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rm4_q[i] <= rm[i][30:0];
      end
      ov4_q <= ov_r;
      dd4_q <= dd3_q;
      op4_q <= op3_q;
      pl4_q <= pl3_q;
      sp4_q <= sp3_q;
      nr4_q <= nr3_q;
      in4_q <= in3_q;
      st4_q <= st3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= 62'(rm4_q[i]) * 62'(rm4_q[i]);
      end
      ov5_q <= ov4_q;
      dd5_q <= dd4_q;
      op5_q <= op4_q;
      pl5_q <= pl4_q;
      sp5_q <= sp4_q;
      nr5_q <= nr4_q;
      in5_q <= in4_q;
      st5_q <= st4_q;
    end
  end

  always_comb begin
    n_s6 = 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
    if (ov5_q || n_s6 > SqCap) begin
      n_s6 = SqCap;
    end
    n4_s6 = n_s6 << 2;
    nr_ok = nr5_q & (n4_s6 <= 64'(dd5_q));
    rd_ok = st5_q & (((n4_s6 > 64'(dd5_q)) ? (n4_s6 - 64'(dd5_q)) : (64'(dd5_q) - n4_s6))
                     <= 64'(tr));
    cyl   = (nr5_q | in5_q) & (nr_ok | rd_ok);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      unique case (op5_q)
        OP_PLANE:    res_q <= pl5_q;
        OP_CYLINDER: res_q <= cyl;
        OP_SPHERE:   res_q <= sp5_q;
        OP_NONE:     res_q <= 1'b0;
        default:     res_q <= 1'b0;
      endcase
    end
  end

endmodule

// ===== design/point_on_surface_test.sv =====
// Top level of the point-on-surface test.
// One request is accepted per clock cycle while in_stall_o is low, and each
// gives exactly one result, in order, after passing through the two-entry
// input queue and then the arithmetic pipeline of the back part. A stalled
// result holds the whole back part until it is taken. The tolerance register
// sets the tolerance of the plane, sphere and cylinder tests; the user must
// write it while the block holds no request; the block does not enforce it.
module point_on_surface_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  input  logic signed [31:0] ref_z_i,
  input  logic signed [17:0] axis_x_i,
  input  logic signed [17:0] axis_y_i,
  input  logic signed [17:0] axis_z_i,
  input  logic [30:0]        diameter_i,
  input  logic [30:0]        height_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               on_surface_o
);
  import pos_pkg::*;

  logic [15:0] tol_q;
  entry_t      fr_entry, q_entry;
  queue_ctl_t  qctl;
  logic        q_full, q_empty, push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign qctl.push = push;
  assign qctl.pop  = pop;

  pos_front u_front (
    .in_valid_i  (in_valid_i),
    .queue_full_i(q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .operation_i (operation_i),
    .ref_x_i     (ref_x_i),
    .ref_y_i     (ref_y_i),
    .ref_z_i     (ref_z_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .diameter_i  (diameter_i),
    .height_i    (height_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .entry_o     (fr_entry)
  );

  pos_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qctl),
    .entry_i(fr_entry),
    .entry_o(q_entry),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pos_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .avail_i     (~q_empty),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .on_surface_o(on_surface_o)
  );

endmodule

// ===== design/pos_checker.sv =====
// Port-level checks for the point-on-surface test and their binding.
module pos_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic on_surface_o
);
  import pos_pkg::*;

  localparam int unsigned Cap = QUEUE_DEPTH + BACK_STAGES;

  logic [4:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 5'(in_acc) - 5'(out_acc);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(on_surface_o))
    else $error("stalled result changed");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without pending request");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 5'(Cap))
    else $error("too many requests in flight");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 5'(Cap) && !out_acc |-> in_stall_o)
    else $error("request taken while full");

endmodule

bind point_on_surface_test pos_checker u_pos_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .on_surface_o(on_surface_o)
);
